// File: src/lspg_pkg.sv
`default_nettype none

package lspg_pkg;

  localparam int unsigned PixelCountDefault = 60;

  localparam logic [8:0] ResetHue  = 9'd99;
  localparam logic [7:0] ResetSat  = 8'd104;
  localparam logic [7:0] ResetVal  = 8'd247;

  localparam logic [7:0] ValDim       = 8'd70;
  localparam logic [7:0] ScrollSat    = 8'd200;
  localparam logic [7:0] StripeSat    = 8'd214;
  localparam logic [8:0] BlueHue      = 9'd99;
  localparam logic [7:0] BlueSat      = 8'd127;
  localparam logic [8:0] LimeHue      = 9'd58;
  localparam logic [7:0] LimeSat      = 8'd255;
  localparam logic [8:0] HalfHueA     = 9'd56;
  localparam logic [8:0] HalfHueB     = 9'd272;
  localparam logic [8:0] FullHueA     = 9'd0;
  localparam logic [8:0] FullHueB     = 9'd180;

  localparam logic [4:0] BlinkOnTicks  = 5'd10;
  localparam logic [4:0] BlinkAllTicks = 5'd20;
  localparam logic [2:0] StripeLast    = 3'd5;

  localparam logic [3:0] DisRed          = 4'd1;
  localparam logic [3:0] DisOrange       = 4'd2;
  localparam logic [3:0] DisPurple       = 4'd3;
  localparam logic [3:0] DisBlue         = 4'd4;
  localparam logic [3:0] DisBluePurple   = 4'd5;
  localparam logic [3:0] ClimbBlue       = 4'd0;
  localparam logic [3:0] ClimbBluePurple = 4'd1;
  localparam logic [3:0] ClimbPurple     = 4'd2;
  localparam logic [3:0] ClimbRed        = 4'd3;
  localparam logic [3:0] ClimbOrange     = 4'd4;
  localparam logic [3:0] ClimbStripeHalf = 4'd5;
  localparam logic [3:0] ClimbStripeFull = 4'd6;
  localparam logic [3:0] CodeLimeBlink   = 4'd9;
  localparam logic [3:0] CodeBluePurple  = 4'd5;

  typedef struct packed {
    logic       func;
    logic [3:0] colour_code;
    logic       auto_climbing;
    logic       blink_override;
    logic       index_full;
  } lspg_in_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       last;
  } lspg_out_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } pixel_t;

  typedef enum logic [3:0] {
    PAT_RAINBOW,
    PAT_RED,
    PAT_ORANGE,
    PAT_PURPLE,
    PAT_BLUE_PURPLE,
    PAT_BLUE,
    PAT_STRIPE_HALF,
    PAT_STRIPE_FULL,
    PAT_LIME_ON,
    PAT_LIME_OFF,
    PAT_HOLD
  } pattern_e;

  typedef enum logic [1:0] {
    MOD_180,
    MOD_8,
    MOD_10,
    MOD_12
  } mod_sel_e;

endpackage

`default_nettype wire

// File: src/lspg_stream_if.sv
`default_nettype none

interface lspg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/led_strip_pattern_generator.sv
// Channel  Dir  Payload                                                Handshake
// in_i     in   func, colour_code, auto_climbing, blink_override,      valid/ready
//               index_full
// out_o    out  pixel_index, hue, saturation, brightness, last         valid/ready
//
// Each tick runs as an accept step, a setup step in which the shared modulo unit
// advances the scroll offset of a scrolling pattern, and a pixel loop in which the
// same unit reduces each pixel's hue in turn.
// Input is ready only while the sequencer is idle; output stalls hold the pixel loop.
// Reset clears all counters; the frame reads as the start-up colour until first written.
`default_nettype none

module led_strip_pattern_generator #(
  parameter int unsigned PIXEL_COUNT = lspg_pkg::PixelCountDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  lspg_stream_if.sink   in_i,
  lspg_stream_if.source out_o
);
  import lspg_pkg::*;

  localparam int unsigned StepQ = 180 / PIXEL_COUNT;
  localparam int unsigned StepR = 180 % PIXEL_COUNT;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e     state_q, state_d;
  pattern_e   pat_q, pat_d;
  logic [7:0] scroll_hue_q, scroll_hue_d;
  logic [7:0] scroll_base_q;
  logic [2:0] stripe_phase_q, stripe_phase_d;
  logic [2:0] stripe_div_q, stripe_div_d;
  logic [4:0] blink_q, blink_d;
  logic       frame_init_q;
  logic [5:0] idx_q, idx_d;
  logic [7:0] off_q, off_d;
  logic [6:0] rem_q, rem_d;
  logic [2:0] s6_q, s6_d;
  logic       out_valid_q;
  lspg_out_t  out_data_q;
  pixel_t     rd_q;
  pixel_t     frame_mem [PIXEL_COUNT];

  lspg_in_t   req;
  logic       in_fire;
  logic       step;
  logic       last_pix;

  // modulo unit
  mod_sel_e   mod_sel;
  logic [8:0] mod_x;
  logic [7:0] mod_recip;
  logic [3:0] mod_m;
  logic [16:0] mod_prod;
  logic [5:0] mod_quo;
  logic [8:0] mod_sub;
  logic [7:0] mod_r;

  logic [8:0] base_hue;
  logic [8:0] hue_a;
  logic [8:0] hue_b;
  logic       is_scroll;
  logic       is_stripe;
  logic [1:0] scroll_step;
  pixel_t     new_pix;
  pixel_t     pix_out;
  logic [6:0] rem_sum;

  assign req      = in_i.data;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign step     = (state_q == ST_RUN) && (!out_valid_q || out_o.ready);
  assign last_pix = (idx_q == 6'(PIXEL_COUNT - 1));

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // pattern decode and tick counters
  always_comb begin
    pat_d          = PAT_RAINBOW;
    stripe_phase_d = stripe_phase_q;
    stripe_div_d   = stripe_div_q;
    blink_d        = blink_q;
    if (req.func) begin
      case (req.colour_code)
        DisRed:        pat_d = PAT_RED;
        DisOrange:     pat_d = PAT_ORANGE;
        DisPurple:     pat_d = PAT_PURPLE;
        DisBlue:       pat_d = PAT_BLUE;
        DisBluePurple: pat_d = PAT_BLUE_PURPLE;
        default:       pat_d = PAT_RAINBOW;
      endcase
    end else if (req.auto_climbing) begin
      case (req.colour_code)
        ClimbBlue:       pat_d = PAT_BLUE;
        ClimbBluePurple: pat_d = PAT_BLUE_PURPLE;
        ClimbPurple:     pat_d = PAT_PURPLE;
        ClimbRed:        pat_d = PAT_RED;
        ClimbOrange:     pat_d = PAT_ORANGE;
        ClimbStripeHalf: pat_d = PAT_STRIPE_HALF;
        ClimbStripeFull: pat_d = PAT_STRIPE_FULL;
        default:         pat_d = PAT_RAINBOW;
      endcase
    end else if (req.colour_code == CodeLimeBlink && !req.blink_override) begin
      stripe_phase_d = '0;
      if (blink_q < BlinkOnTicks) begin
        pat_d   = PAT_LIME_ON;
        blink_d = blink_q + 5'd1;
      end else if (blink_q < BlinkAllTicks) begin
        pat_d   = PAT_LIME_OFF;
        blink_d = blink_q + 5'd1;
      end else begin
        pat_d   = PAT_HOLD;
        blink_d = '0;
      end
    end else if (req.colour_code == CodeBluePurple) begin
      stripe_phase_d = '0;
      pat_d          = PAT_BLUE_PURPLE;
    end else if (req.index_full) begin
      pat_d = PAT_STRIPE_FULL;
    end else begin
      pat_d = PAT_STRIPE_HALF;
    end

    if (pat_d == PAT_STRIPE_HALF || pat_d == PAT_STRIPE_FULL) begin
      if (stripe_div_q >= StripeLast) begin
        stripe_div_d   = '0;
        stripe_phase_d = (stripe_phase_q == StripeLast) ? 3'd0 : stripe_phase_q + 3'd1;
      end else begin
        stripe_div_d = stripe_div_q + 3'd1;
      end
    end
  end

  // pattern attributes
  always_comb begin
    mod_sel     = MOD_180;
    base_hue    = '0;
    hue_a       = FullHueA;
    hue_b       = FullHueB;
    is_scroll   = 1'b0;
    is_stripe   = 1'b0;
    scroll_step = 2'd1;
    case (pat_q)
      PAT_RAINBOW: begin
        is_scroll   = 1'b1;
        scroll_step = 2'd3;
      end
      PAT_RED: begin
        is_scroll = 1'b1;
        mod_sel   = MOD_8;
      end
      PAT_ORANGE: begin
        is_scroll = 1'b1;
        mod_sel   = MOD_10;
        base_hue  = 9'd182;
      end
      PAT_BLUE_PURPLE: begin
        is_scroll = 1'b1;
        mod_sel   = MOD_10;
        base_hue  = 9'd115;
      end
      PAT_PURPLE: begin
        is_scroll = 1'b1;
        mod_sel   = MOD_12;
        base_hue  = 9'd135;
      end
      PAT_STRIPE_HALF: begin
        is_stripe = 1'b1;
        hue_a     = HalfHueA;
        hue_b     = HalfHueB;
      end
      PAT_STRIPE_FULL: begin
        is_stripe = 1'b1;
      end
      default: ;
    endcase
  end

  // shared modulo unit: x < 359, reciprocal multiply for 10 and 12
  always_comb begin
    if (state_q == ST_SETUP) begin
      mod_x = 9'(scroll_base_q) + 9'(scroll_step);
    end else begin
      mod_x = 9'(scroll_base_q) + 9'(off_q);
    end
    mod_recip = (mod_sel == MOD_10) ? 8'd205 : 8'd171;
    mod_m     = (mod_sel == MOD_10) ? 4'd10 : 4'd12;
    mod_prod  = 17'(mod_x) * 17'(mod_recip);
    mod_quo   = mod_prod[16:11];
    mod_sub   = 9'(mod_quo) * 9'(mod_m);
    unique case (mod_sel)
      MOD_8:   mod_r = 8'(mod_x[2:0]);
      MOD_180: mod_r = (mod_x >= 9'd180) ? 8'(mod_x - 9'd180) : mod_x[7:0];
      default: mod_r = 8'(mod_x - mod_sub);
    endcase
  end

  always_comb begin
    new_pix = '{hue: BlueHue, sat: BlueSat, val: ValDim};
    if (is_scroll) begin
      new_pix = '{hue: 9'(mod_r) + base_hue, sat: ScrollSat, val: ValDim};
    end else if (is_stripe) begin
      new_pix = '{hue: (s6_q < 3'd3) ? hue_a : hue_b, sat: StripeSat, val: ValDim};
    end else if (pat_q == PAT_LIME_ON) begin
      new_pix = '{hue: LimeHue, sat: LimeSat, val: ValDim};
    end else if (pat_q == PAT_LIME_OFF) begin
      new_pix = '{hue: LimeHue, sat: LimeSat, val: 8'd0};
    end
    if (pat_q == PAT_HOLD) begin
      pix_out = frame_init_q ? rd_q : '{hue: ResetHue, sat: ResetSat, val: ResetVal};
    end else begin
      pix_out = new_pix;
    end
  end

  // sequencer and pixel counters
  always_comb begin
    state_d      = state_q;
    scroll_hue_d = scroll_hue_q;
    idx_d        = idx_q;
    off_d        = off_q;
    rem_d        = rem_q;
    s6_d         = s6_q;
    rem_sum      = rem_q + 7'(StepR);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SETUP;
          idx_d   = '0;
          off_d   = '0;
          rem_d   = '0;
          s6_d    = stripe_phase_d;
        end
      end
      ST_SETUP: begin
        if (is_scroll) begin
          scroll_hue_d = mod_r;
        end
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step) begin
          if (last_pix) begin
            state_d = ST_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
          if (rem_sum >= 7'(PIXEL_COUNT)) begin
            rem_d = rem_sum - 7'(PIXEL_COUNT);
            off_d = off_q + 8'(StepQ) + 8'd1;
          end else begin
            rem_d = rem_sum;
            off_d = off_q + 8'(StepQ);
          end
          s6_d = (s6_q == StripeLast) ? 3'd0 : s6_q + 3'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pat_q          <= PAT_RAINBOW;
      scroll_hue_q   <= '0;
      stripe_phase_q <= '0;
      stripe_div_q   <= '0;
      blink_q        <= '0;
      frame_init_q   <= 1'b0;
      idx_q          <= '0;
      off_q          <= '0;
      rem_q          <= '0;
      s6_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      scroll_hue_q <= scroll_hue_d;
      idx_q        <= idx_d;
      off_q        <= off_d;
      rem_q        <= rem_d;
      s6_q         <= s6_d;
      if (in_fire) begin
        pat_q          <= pat_d;
        stripe_phase_q <= stripe_phase_d;
        stripe_div_q   <= stripe_div_d;
        blink_q        <= blink_d;
        if (pat_d != PAT_HOLD) begin
          frame_init_q <= 1'b1;
        end
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scroll_base_q <= scroll_hue_q;
    end
    if (step) begin
      out_data_q <= '{pixel_index: idx_q, hue: pix_out.hue, saturation: pix_out.sat,
                      brightness: pix_out.val, last: last_pix};
    end
  end

  // frame store: write during a drawing tick, read ahead for a repeat tick
  always_ff @(posedge clk_i) begin
    if (step && pat_q != PAT_HOLD) begin
      frame_mem[idx_q] <= new_pix;
    end
    rd_q <= frame_mem[idx_d];
  end

  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> {1'b0, idx_q} < 7'(PIXEL_COUNT))
    else $error("pixel index beyond strip");

  a_scroll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scroll_hue_q < 8'd180)
    else $error("scroll offset out of range");

  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stripe_phase_q <= StripeLast && stripe_div_q <= StripeLast && blink_q <= BlinkAllTicks)
    else $error("tick counter out of range");

  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_pix |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after final pixel");

endmodule

`default_nettype wire
